/* src/rvx_pkg.sv */
// ---------------------------------------------------------------------------
// rvx_pkg
// Shared types and codes for the rv64i subset execute unit: opcodes, command
// and status codes, register indexes and the controller/datapath interface.
// ---------------------------------------------------------------------------
`default_nettype none

package rvx_pkg;

    // item command codes
    localparam logic [2:0] CMD_STEP  = 3'd0;
    localparam logic [2:0] CMD_RDREG = 3'd1;
    localparam logic [2:0] CMD_WRREG = 3'd2;
    localparam logic [2:0] CMD_RDMEM = 3'd3;
    localparam logic [2:0] CMD_WRMEM = 3'd4;

    // result status codes
    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_ILLEGAL = 3'd1;
    localparam logic [2:0] STS_FAULT   = 3'd2;
    localparam logic [2:0] STS_PAST    = 3'd3;
    localparam logic [2:0] STS_BADREG  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_CODE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_BP_EN      = 2'd1;
    localparam logic [1:0] CFG_BP_ADDR    = 2'd2;

    // debug register index of the program counter
    localparam logic [5:0] REG_PC = 6'd32;

    // opcodes
    localparam logic [6:0] OP_LOAD  = 7'h03;
    localparam logic [6:0] OP_IMM   = 7'h13;
    localparam logic [6:0] OP_AUIPC = 7'h17;
    localparam logic [6:0] OP_IMMW  = 7'h1b;
    localparam logic [6:0] OP_STORE = 7'h23;
    localparam logic [6:0] OP_REG   = 7'h33;
    localparam logic [6:0] OP_LUI   = 7'h37;
    localparam logic [6:0] OP_REGW  = 7'h3b;
    localparam logic [6:0] OP_JALR  = 7'h67;
    localparam logic [6:0] OP_JAL   = 7'h6f;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_BYTE = 3'd0;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_DBL  = 3'd3;
    localparam logic [6:0] F7_ADD  = 7'd0;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic accept;
        logic check;
        logic rd_seq;
        logic wr_seq;
        logic decode;
        logic rs1;
        logic exec;
        logic achk;
        logic lwb;
        logic regrd;
        logic finish;
    } rvx_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic seq_done;
        logic chk_fail;
        logic is_step;
        logic is_rdreg;
        logic is_rdmem;
        logic is_wrmem;
        logic ex_illegal;
        logic ex_mem;
        logic ex_load;
        logic acc_fault;
        logic out_full;
    } rvx_sts_t;

endpackage

`default_nettype wire

/* src/rvx_ctrl.sv */
// ---------------------------------------------------------------------------
// rvx_ctrl
// Sequencer for the execute unit: memory clearing after reset, item intake,
// fetch, decode, execute, data access and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module rvx_ctrl
    import rvx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire rvx_sts_t sts,
    output rvx_cmd_t      ctl
);

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_CHECK  = 15'b000000000000100,
        S_FETCH  = 15'b000000000001000,
        S_DECODE = 15'b000000000010000,
        S_RS1    = 15'b000000000100000,
        S_EXEC   = 15'b000000001000000,
        S_ACHK   = 15'b000000010000000,
        S_LOAD   = 15'b000000100000000,
        S_LWB    = 15'b000001000000000,
        S_STORE  = 15'b000010000000000,
        S_MRD    = 15'b000100000000000,
        S_MWR    = 15'b001000000000000,
        S_REGRD  = 15'b010000000000000,
        S_FINISH = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.chk_fail)
                    state_next = S_FINISH;
                else if (sts.is_step)
                    state_next = S_FETCH;
                else if (sts.is_rdreg)
                    state_next = S_REGRD;
                else if (sts.is_rdmem)
                    state_next = S_MRD;
                else if (sts.is_wrmem)
                    state_next = S_MWR;
                else
                    state_next = S_FINISH;
            end
            S_FETCH:
            begin
                if (sts.seq_done)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                state_next = S_RS1;
            end
            S_RS1:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.ex_illegal)
                    state_next = S_FINISH;
                else if (sts.ex_mem)
                    state_next = S_ACHK;
                else
                    state_next = S_FINISH;
            end
            S_ACHK:
            begin
                if (sts.acc_fault)
                    state_next = S_FINISH;
                else if (sts.ex_load)
                    state_next = S_LOAD;
                else
                    state_next = S_STORE;
            end
            S_LOAD:
            begin
                if (sts.seq_done)
                    state_next = S_LWB;
            end
            S_LWB:
            begin
                state_next = S_FINISH;
            end
            S_STORE, S_MRD, S_MWR:
            begin
                if (sts.seq_done)
                    state_next = S_FINISH;
            end
            S_REGRD:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!sts.out_full)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        in_stall   = (state_reg != S_IDLE);
        ctl        = '0;
        ctl.clear  = (state_reg == S_CLEAR);
        ctl.accept = (state_reg == S_IDLE) && in_valid;
        ctl.check  = (state_reg == S_CHECK);
        ctl.rd_seq = (state_reg == S_FETCH) || (state_reg == S_LOAD) || (state_reg == S_MRD);
        ctl.wr_seq = (state_reg == S_STORE) || (state_reg == S_MWR);
        ctl.decode = (state_reg == S_DECODE);
        ctl.rs1    = (state_reg == S_RS1);
        ctl.exec   = (state_reg == S_EXEC);
        ctl.achk   = (state_reg == S_ACHK);
        ctl.lwb    = (state_reg == S_LWB);
        ctl.regrd  = (state_reg == S_REGRD);
        ctl.finish = (state_reg == S_FINISH);
    end

endmodule

`default_nettype wire

/* src/rvx_dp.sv */
// ---------------------------------------------------------------------------
// rvx_dp
// Datapath of the execute unit: program counter, register file, byte-wide
// data memory, decoder, shared adder, configuration and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module rvx_dp
    import rvx_pkg::*;
#(
    parameter int MEM_BYTES = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire rvx_cmd_t    ctl,
    output rvx_sts_t         sts,
    input  wire logic [2:0]  cmd,
    input  wire logic [5:0]  reg_index,
    input  wire logic [11:0] addr,
    input  wire logic [3:0]  byte_count,
    input  wire logic [63:0] wdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        out_stall,
    output logic             out_valid,
    output logic [2:0]       status,
    output logic [63:0]      rdata,
    output logic [63:0]      pc_value,
    output logic             tohost_set,
    output logic             at_breakpoint
);

    localparam int          AW         = $clog2(MEM_BYTES);
    localparam logic [63:0] MEM_TOP    = 64'(MEM_BYTES);
    localparam logic [63:0] RF_SP_INIT = 64'(MEM_BYTES - 4);
    localparam logic [AW-1:0] TOHOST_A = AW'(MEM_BYTES - 4);
    localparam logic [AW-1:0] LAST_A   = AW'(MEM_BYTES - 1);
    localparam logic [17:0] MEM_TOP18  = 18'(MEM_BYTES);

    // configuration
    logic [12:0] code_limit_reg;
    logic        bp_en_reg;
    logic [63:0] bp_addr_reg;

    // latched item
    logic [2:0]  cmd_reg;
    logic [5:0]  ri_reg;
    logic [11:0] addr_reg;
    logic [3:0]  cnt_reg;
    logic [63:0] wdata_reg;

    // architectural and working registers
    logic [63:0] pc_reg;
    logic [63:0] opc_reg;
    logic [31:0] instr_reg;
    logic [63:0] rs1_reg;
    logic [63:0] rs2_reg;
    logic [63:0] ea_reg;
    logic [63:0] buf_reg;
    logic [63:0] res_rdata_reg;
    logic [2:0]  status_reg;

    // byte sequencer
    logic [AW-1:0] seq_base_reg;
    logic [3:0]    seq_n_reg;
    logic [3:0]    seq_idx_reg;
    logic          pend_reg;
    logic [2:0]    pend_idx_reg;
    logic          seq_issue;
    logic [AW-1:0] seq_addr;

    // data memory
    logic [7:0]    mem [MEM_BYTES];
    logic [7:0]    mem_q_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [AW-1:0] clr_idx_reg;
    logic          tohost_reg;

    // register file
    logic [63:0] rf_mem [32];
    logic [31:0] rf_valid_reg;
    logic [63:0] rf_q_reg;
    logic [4:0]  rf_rsel_reg;
    logic        rf_rvalid_reg;
    logic [4:0]  rf_raddr;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [63:0] rf_wdata;
    logic [63:0] rf_val;

    // output registers
    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [63:0] out_rdata_reg;
    logic [63:0] out_pc_reg;
    logic        out_tohost_reg;
    logic        out_bp_reg;

    // check results
    logic [2:0]  chk_status;
    logic        past;
    logic        ffault;
    logic        badreg;
    logic        mbad;
    logic [17:0] msum;

    // decode fields
    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [63:0] immi;
    logic [63:0] imms;
    logic [63:0] immu;
    logic [63:0] immj;
    logic [63:0] add_a;
    logic [63:0] add_b;
    logic [63:0] sum;
    logic        slt;
    logic        ex_illegal;
    logic        ex_wr;
    logic        ex_jump;
    logic        ex_mem;
    logic        ex_load;
    logic [3:0]  ls_size;
    logic [63:0] ex_res;
    logic [63:0] ex_target;
    logic [63:0] load_val;
    logic        acc_fault;
    logic        out_full;

    // item checks
    always_comb
    begin
        past   = pc_reg >= {51'b0, code_limit_reg};
        ffault = pc_reg > (MEM_TOP - 64'd4);
        badreg = ri_reg > REG_PC;
        msum   = 18'(addr_reg) + 18'(cnt_reg);
        mbad   = (cnt_reg == 4'd0) || (cnt_reg > 4'd8) || (msum > MEM_TOP18);
        case (cmd_reg)
            CMD_STEP:             chk_status = past ? STS_PAST : (ffault ? STS_FAULT : STS_OK);
            CMD_RDREG, CMD_WRREG: chk_status = badreg ? STS_BADREG : STS_OK;
            CMD_RDMEM, CMD_WRMEM: chk_status = mbad ? STS_FAULT : STS_OK;
            default:              chk_status = STS_OK;
        endcase
    end

    // instruction fields
    always_comb
    begin
        op   = instr_reg[6:0];
        rd   = instr_reg[11:7];
        f3   = instr_reg[14:12];
        f7   = instr_reg[31:25];
        immi = {{52{instr_reg[31]}}, instr_reg[31:20]};
        imms = {{52{instr_reg[31]}}, instr_reg[31:25], instr_reg[11:7]};
        immu = {{32{instr_reg[31]}}, instr_reg[31:12], 12'b0};
        immj = {{43{instr_reg[31]}}, instr_reg[31], instr_reg[19:12], instr_reg[20],
                instr_reg[30:21], 1'b0};
    end

    // shared adder operands
    always_comb
    begin
        add_a = rs1_reg;
        add_b = immi;
        case (op)
            OP_STORE:        add_b = imms;
            OP_REG, OP_REGW: add_b = rf_val;
            OP_AUIPC:
            begin
                add_a = opc_reg;
                add_b = immu;
            end
            OP_JAL:
            begin
                add_a = opc_reg;
                add_b = immj;
            end
            OP_LUI:
            begin
                add_a = 64'd0;
                add_b = immu;
            end
            default:
            begin
                add_a = rs1_reg;
                add_b = immi;
            end
        endcase
        sum = add_a + add_b;
        slt = $signed(rs1_reg) < $signed(immi);
    end

    // execute decode
    always_comb
    begin
        ex_illegal = 1'b1;
        ex_wr      = 1'b0;
        ex_jump    = 1'b0;
        ex_mem     = 1'b0;
        ex_load    = 1'b0;
        ls_size    = 4'd4;
        ex_res     = sum;
        ex_target  = sum;
        case (op)
            OP_LOAD:
            begin
                ex_load = 1'b1;
                if (f3 == F3_WORD)
                begin
                    ex_illegal = 1'b0;
                    ex_mem     = 1'b1;
                    ls_size    = 4'd4;
                end
                else if (f3 == F3_DBL)
                begin
                    ex_illegal = 1'b0;
                    ex_mem     = 1'b1;
                    ls_size    = 4'd8;
                end
            end
            OP_IMM:
            begin
                if (f3 == F3_ADD)
                begin
                    ex_illegal = 1'b0;
                    ex_wr      = 1'b1;
                end
                else if (f3 == F3_SLT)
                begin
                    ex_illegal = 1'b0;
                    ex_wr      = 1'b1;
                    ex_res     = {63'b0, slt};
                end
            end
            OP_AUIPC, OP_LUI:
            begin
                ex_illegal = 1'b0;
                ex_wr      = 1'b1;
            end
            OP_IMMW:
            begin
                if (f3 == F3_ADD)
                begin
                    ex_illegal = 1'b0;
                    ex_wr      = 1'b1;
                    ex_res     = {{32{sum[31]}}, sum[31:0]};
                end
            end
            OP_STORE:
            begin
                if (f3 == F3_BYTE)
                begin
                    ex_illegal = 1'b0;
                    ex_mem     = 1'b1;
                    ls_size    = 4'd1;
                end
                else if (f3 == F3_WORD)
                begin
                    ex_illegal = 1'b0;
                    ex_mem     = 1'b1;
                    ls_size    = 4'd4;
                end
                else if (f3 == F3_DBL)
                begin
                    ex_illegal = 1'b0;
                    ex_mem     = 1'b1;
                    ls_size    = 4'd8;
                end
            end
            OP_REG:
            begin
                if ((f3 == F3_ADD) && (f7 == F7_ADD))
                begin
                    ex_illegal = 1'b0;
                    ex_wr      = 1'b1;
                end
            end
            OP_REGW:
            begin
                if ((f3 == F3_ADD) && (f7 == F7_ADD))
                begin
                    ex_illegal = 1'b0;
                    ex_wr      = 1'b1;
                    ex_res     = {{32{sum[31]}}, sum[31:0]};
                end
            end
            OP_JALR:
            begin
                ex_illegal = 1'b0;
                ex_wr      = 1'b1;
                ex_jump    = 1'b1;
                ex_res     = pc_reg;
                ex_target  = {sum[63:1], 1'b0};
            end
            OP_JAL:
            begin
                ex_illegal = 1'b0;
                ex_wr      = 1'b1;
                ex_jump    = 1'b1;
                ex_res     = pc_reg;
            end
            default:
            begin
                ex_illegal = 1'b1;
            end
        endcase
        acc_fault = ea_reg > (MEM_TOP - 64'(ls_size));
        load_val  = (f3 == F3_WORD) ? {{32{buf_reg[31]}}, buf_reg[31:0]} : buf_reg;
    end

    // byte sequencer address and memory port select
    always_comb
    begin
        seq_issue = (ctl.rd_seq || ctl.wr_seq) && (seq_idx_reg < seq_n_reg);
        seq_addr  = seq_base_reg + AW'(seq_idx_reg);
        mem_we    = ctl.clear || (ctl.wr_seq && seq_issue);
        mem_wa    = ctl.clear ? clr_idx_reg : seq_addr;
        mem_wd    = ctl.clear ? 8'd0 : buf_reg[{seq_idx_reg[2:0], 3'b000} +: 8];
    end

    // data memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        mem_q_reg <= mem[seq_addr];
    end

    // register file port select
    always_comb
    begin
        rf_raddr = 5'd0;
        if (ctl.check)
            rf_raddr = ri_reg[4:0];
        else if (ctl.decode)
            rf_raddr = buf_reg[19:15];
        else if (ctl.rs1)
            rf_raddr = instr_reg[24:20];

        rf_we    = 1'b0;
        rf_waddr = rd;
        rf_wdata = ex_res;
        if (ctl.check && (cmd_reg == CMD_WRREG) && (ri_reg < REG_PC))
        begin
            rf_we    = 1'b1;
            rf_waddr = ri_reg[4:0];
            rf_wdata = wdata_reg;
        end
        else if (ctl.exec && ex_wr)
        begin
            rf_we = 1'b1;
        end
        else if (ctl.lwb)
        begin
            rf_we    = 1'b1;
            rf_wdata = load_val;
        end

        // x0 reads zero, entries never written read their reset value
        if (rf_rsel_reg == 5'd0)
            rf_val = 64'd0;
        else if (rf_rvalid_reg)
            rf_val = rf_q_reg;
        else if (rf_rsel_reg == 5'd2)
            rf_val = RF_SP_INIT;
        else
            rf_val = 64'd0;
    end

    // register file array
    always_ff @(posedge clk)
    begin
        if (rf_we && (rf_waddr != 5'd0))
            rf_mem[rf_waddr] <= rf_wdata;
        rf_q_reg      <= rf_mem[rf_raddr];
        rf_rsel_reg   <= rf_raddr;
        rf_rvalid_reg <= rf_valid_reg[rf_raddr];
    end

    assign out_full = out_valid_reg && out_stall;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_limit_reg <= 13'd0;
            bp_en_reg      <= 1'b0;
            bp_addr_reg    <= '1;
            pc_reg         <= 64'd0;
            rf_valid_reg   <= 32'd0;
            clr_idx_reg    <= '0;
            tohost_reg     <= 1'b0;
            seq_idx_reg    <= 4'd0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CODE_LIMIT: code_limit_reg <= cfg_data[12:0];
                    CFG_BP_EN:      bp_en_reg      <= cfg_data[0];
                    CFG_BP_ADDR:    bp_addr_reg    <= cfg_data;
                    default:        ;
                endcase
            end

            // program counter
            if (ctl.check && (cmd_reg == CMD_WRREG) && (ri_reg == REG_PC))
                pc_reg <= wdata_reg;
            else if (ctl.decode)
                pc_reg <= pc_reg + 64'd4;
            else if (ctl.exec && ex_jump)
                pc_reg <= ex_target;

            if (rf_we && (rf_waddr != 5'd0))
                rf_valid_reg[rf_waddr] <= 1'b1;

            // clearing sweep
            if (ctl.clear)
                clr_idx_reg <= clr_idx_reg + AW'(1);

            // tohost byte mirror
            if (mem_we && (mem_wa == TOHOST_A))
                tohost_reg <= (mem_wd != 8'd0);

            // byte sequencer
            if (ctl.accept || ctl.check || ctl.achk)
                seq_idx_reg <= 4'd0;
            else if (seq_issue)
                seq_idx_reg <= seq_idx_reg + 4'd1;
            pend_reg <= ctl.rd_seq && seq_issue;

            // result transfer
            if (ctl.finish && !out_full)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= seq_idx_reg[2:0];

        if (ctl.accept)
        begin
            cmd_reg       <= cmd;
            ri_reg        <= reg_index;
            addr_reg      <= addr;
            cnt_reg       <= byte_count;
            wdata_reg     <= wdata;
            buf_reg       <= (cmd == CMD_WRMEM) ? wdata : 64'd0;
            seq_base_reg  <= AW'({52'b0, addr});
            seq_n_reg     <= byte_count;
            status_reg    <= STS_OK;
            res_rdata_reg <= 64'd0;
        end

        if (ctl.check)
        begin
            status_reg <= chk_status;
            if (cmd_reg == CMD_STEP)
            begin
                seq_base_reg <= pc_reg[AW-1:0];
                seq_n_reg    <= 4'd4;
                buf_reg      <= 64'd0;
            end
        end

        // gather read bytes
        if (pend_reg)
            buf_reg[{pend_idx_reg, 3'b000} +: 8] <= mem_q_reg;

        if (ctl.decode)
        begin
            instr_reg <= buf_reg[31:0];
            opc_reg   <= pc_reg;
        end

        if (ctl.rs1)
            rs1_reg <= rf_val;

        if (ctl.exec)
        begin
            rs2_reg <= rf_val;
            ea_reg  <= sum;
            if (ex_illegal)
                status_reg <= STS_ILLEGAL;
        end

        if (ctl.achk)
        begin
            seq_base_reg <= ea_reg[AW-1:0];
            seq_n_reg    <= ls_size;
            buf_reg      <= ex_load ? 64'd0 : rs2_reg;
            if (acc_fault)
                status_reg <= STS_FAULT;
        end

        if (ctl.regrd)
            res_rdata_reg <= (ri_reg == REG_PC) ? pc_reg : rf_val;

        // result register load
        if (ctl.finish && !out_full)
        begin
            out_status_reg <= status_reg;
            if ((status_reg == STS_OK) && (cmd_reg == CMD_RDREG))
                out_rdata_reg <= res_rdata_reg;
            else if ((status_reg == STS_OK) && (cmd_reg == CMD_RDMEM))
                out_rdata_reg <= buf_reg;
            else
                out_rdata_reg <= 64'd0;
            out_pc_reg     <= pc_reg;
            out_tohost_reg <= tohost_reg;
            out_bp_reg     <= bp_en_reg && (pc_reg == bp_addr_reg);
        end
    end

    // status to controller
    always_comb
    begin
        sts            = '0;
        sts.clr_done   = (clr_idx_reg == LAST_A);
        sts.seq_done   = (seq_idx_reg == seq_n_reg);
        sts.chk_fail   = (chk_status != STS_OK);
        sts.is_step    = (cmd_reg == CMD_STEP);
        sts.is_rdreg   = (cmd_reg == CMD_RDREG);
        sts.is_rdmem   = (cmd_reg == CMD_RDMEM);
        sts.is_wrmem   = (cmd_reg == CMD_WRMEM);
        sts.ex_illegal = ex_illegal;
        sts.ex_mem     = ex_mem;
        sts.ex_load    = ex_load;
        sts.acc_fault  = acc_fault;
        sts.out_full   = out_full;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign rdata         = out_rdata_reg;
    assign pc_value      = out_pc_reg;
    assign tohost_set    = out_tohost_reg;
    assign at_breakpoint = out_bp_reg;

endmodule

`default_nettype wire

/* src/rv64i_subset_exec_unit.sv */
// ---------------------------------------------------------------------------
// rv64i_subset_exec_unit
// Small RV64I subset core with a debug port for register and memory access.
//
//   channel   signals                         transfer when
//   input     in_valid / in_stall + fields    in_valid && !in_stall
//   output    out_valid / out_stall + fields  out_valid && !out_stall
//   config    cfg_valid / cfg_ready           cfg_valid && cfg_ready
//
// One item at a time. Memory is byte wide with a registered read, so an
// access of n bytes is made byte by byte; in_stall stays high from the
// transfer until the result is handed off and the unit is idle again.
// After reset the data memory is swept to zero with in_stall high;
// configuration is taken at any time. A held result does not stop the
// next item from being taken; its result waits until the old one leaves.
// ---------------------------------------------------------------------------
`default_nettype none

module rv64i_subset_exec_unit
    import rvx_pkg::*;
#(
    parameter int MEM_BYTES = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [5:0]  reg_index,
    input  wire logic [11:0] addr,
    input  wire logic [3:0]  byte_count,
    input  wire logic [63:0] wdata,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [63:0]      rdata,
    output logic [63:0]      pc_value,
    output logic             tohost_set,
    output logic             at_breakpoint,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    rvx_cmd_t ctl;
    rvx_sts_t sts;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    // sequencer
    rvx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    // datapath
    rvx_dp #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .cmd           (cmd),
        .reg_index     (reg_index),
        .addr          (addr),
        .byte_count    (byte_count),
        .wdata         (wdata),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .rdata         (rdata),
        .pc_value      (pc_value),
        .tohost_set    (tohost_set),
        .at_breakpoint (at_breakpoint)
    );

endmodule

`default_nettype wire

/* tb/rvx_exec_checker.sv */
// ---------------------------------------------------------------------------
// rvx_exec_checker
// Watches the item, result and configuration channels of the rv64i subset
// execute unit, keeps its own copy of the core state, predicts one result per
// accepted item and compares every accepted result field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module rvx_exec_checker
    import rvx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [5:0]  reg_index,
    input  wire logic [11:0] addr,
    input  wire logic [3:0]  byte_count,
    input  wire logic [63:0] wdata,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [2:0]  status,
    input  wire logic [63:0] rdata,
    input  wire logic [63:0] pc_value,
    input  wire logic        tohost_set,
    input  wire logic        at_breakpoint,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_BYTES = 4096;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] rdata;
        logic [63:0] pc;
        logic        tohost;
        logic        bp_hit;
    } core_result_t;

    // shadow core state and configuration
    logic [63:0]  xregs [32];
    logic [63:0]  pc;
    logic [7:0]   dmem [MEM_BYTES];
    logic [12:0]  code_limit;
    logic         bp_en;
    logic [63:0]  bp_addr;
    core_result_t expected_results [$];

    initial errors = 0;
    assign pending = expected_results.size();

    function automatic logic [63:0] xget(input logic [4:0] i);
        return (i == 5'd0) ? 64'd0 : xregs[i];
    endfunction

    task automatic xset(input logic [4:0] i, input logic [63:0] v);
        if (i != 5'd0)
            xregs[i] = v;
    endtask

    function automatic bit fits(input logic [63:0] a, input int unsigned n);
        return (a <= 64'(MEM_BYTES)) && (64'(n) <= 64'(MEM_BYTES) - a);
    endfunction

    function automatic logic [63:0] load_bytes(input logic [63:0] a, input int unsigned n);
        logic [63:0] v;
        v = 64'd0;
        for (int unsigned i = 0; i < n; i++)
            v |= 64'(dmem[int'(a) + i]) << (8 * i);
        return v;
    endfunction

    task automatic store_bytes(input logic [63:0] a, input int unsigned n,
                               input logic [63:0] v);
        for (int unsigned i = 0; i < n; i++)
            dmem[int'(a) + i] = v[8*i +: 8];
    endtask

    // execute one fetched instruction; pc already advanced past it
    task automatic run_instr(input logic [31:0] w, input logic [63:0] old_pc,
                             output logic [2:0] st);
        logic [6:0]  op;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [63:0] immi, immu, imms, immj, ea, t;
        int unsigned nb;
        op   = w[6:0];
        rd   = w[11:7];
        f3   = w[14:12];
        rs1  = w[19:15];
        rs2  = w[24:20];
        f7   = w[31:25];
        immi = {{52{w[31]}}, w[31:20]};
        immu = {{32{w[31]}}, w[31:12], 12'd0};
        imms = {{52{w[31]}}, w[31:25], w[11:7]};
        immj = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        st   = STS_OK;
        case (op)
            OP_LOAD:
                if (f3 != F3_WORD && f3 != F3_DBL) begin
                    st = STS_ILLEGAL;
                end else begin
                    nb = (f3 == F3_WORD) ? 4 : 8;
                    ea = xget(rs1) + immi;
                    if (!fits(ea, nb)) begin
                        st = STS_FAULT;
                    end else begin
                        t = load_bytes(ea, nb);
                        if (nb == 4)
                            t = {{32{t[31]}}, t[31:0]};
                        xset(rd, t);
                    end
                end
            OP_IMM:
                if (f3 == F3_ADD)
                    xset(rd, xget(rs1) + immi);
                else if (f3 == F3_SLT)
                    xset(rd, 64'($signed(xget(rs1)) < $signed(immi)));
                else
                    st = STS_ILLEGAL;
            OP_AUIPC:
                xset(rd, old_pc + immu);
            OP_IMMW:
                if (f3 != F3_ADD) begin
                    st = STS_ILLEGAL;
                end else begin
                    t = xget(rs1) + immi;
                    xset(rd, {{32{t[31]}}, t[31:0]});
                end
            OP_STORE:
                begin
                    if (f3 == F3_BYTE)
                        nb = 1;
                    else if (f3 == F3_WORD)
                        nb = 4;
                    else if (f3 == F3_DBL)
                        nb = 8;
                    else
                        nb = 0;
                    ea = xget(rs1) + imms;
                    if (nb == 0)
                        st = STS_ILLEGAL;
                    else if (!fits(ea, nb))
                        st = STS_FAULT;
                    else
                        store_bytes(ea, nb, xget(rs2));
                end
            OP_REG:
                if (f3 != F3_ADD || f7 != F7_ADD)
                    st = STS_ILLEGAL;
                else
                    xset(rd, xget(rs1) + xget(rs2));
            OP_LUI:
                xset(rd, immu);
            OP_REGW:
                if (f3 != F3_ADD || f7 != F7_ADD) begin
                    st = STS_ILLEGAL;
                end else begin
                    t = xget(rs1) + xget(rs2);
                    xset(rd, {{32{t[31]}}, t[31:0]});
                end
            OP_JALR:
                begin
                    // target from the old rs1, even when rd is rs1
                    t = (xget(rs1) + immi) & ~64'd1;
                    xset(rd, pc);
                    pc = t;
                end
            OP_JAL:
                begin
                    xset(rd, pc);
                    pc = old_pc + immj;
                end
            default:
                st = STS_ILLEGAL;
        endcase
    endtask

    // advance the shadow core by one item and return its result
    task automatic predict_core_result(input logic [2:0] c, input logic [5:0] ri,
                                       input logic [11:0] a, input logic [3:0] n,
                                       input logic [63:0] wd,
                                       output core_result_t r);
        logic [2:0]  st;
        logic [63:0] rv, old_pc;
        logic [31:0] w;
        st = STS_OK;
        rv = 64'd0;
        case (c)
            CMD_STEP:
                if (pc >= {51'd0, code_limit}) begin
                    st = STS_PAST;
                end else if (!fits(pc, 4)) begin
                    st = STS_FAULT;
                end else begin
                    w = 32'(load_bytes(pc, 4));
                    old_pc = pc;
                    pc = pc + 64'd4;
                    run_instr(w, old_pc, st);
                end
            CMD_RDREG, CMD_WRREG:
                if (ri > REG_PC)
                    st = STS_BADREG;
                else if (c == CMD_RDREG)
                    rv = (ri == REG_PC) ? pc : xget(ri[4:0]);
                else if (ri == REG_PC)
                    pc = wd;
                else
                    xset(ri[4:0], wd);
            CMD_RDMEM, CMD_WRMEM:
                if (n == 4'd0 || n > 4'd8 || !fits({52'd0, a}, n))
                    st = STS_FAULT;
                else if (c == CMD_RDMEM)
                    rv = load_bytes({52'd0, a}, n);
                else
                    store_bytes({52'd0, a}, n, wd);
            default:
                ;
        endcase
        r.status = st;
        r.rdata  = rv;
        r.pc     = pc;
        r.tohost = dmem[MEM_BYTES-4] != 8'd0;
        r.bp_hit = bp_en && (pc == bp_addr);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // shadow reset, item predictions, configuration writes and result checks
    always @(posedge clk or negedge rst_n)
    begin
        core_result_t r, e;
        if (!rst_n) begin
            for (int i = 0; i < 32; i++)
                xregs[i] = 64'd0;
            xregs[2] = 64'(MEM_BYTES - 4);
            pc = 64'd0;
            for (int i = 0; i < MEM_BYTES; i++)
                dmem[i] = 8'd0;
            code_limit = 13'd0;
            bp_en = 1'b0;
            bp_addr = '1;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_CODE_LIMIT)
                    code_limit = cfg_data[12:0];
                else if (cfg_index == CFG_BP_EN)
                    bp_en = cfg_data[0];
                else if (cfg_index == CFG_BP_ADDR)
                    bp_addr = cfg_data;
            end
            if (in_valid && !in_stall) begin
                predict_core_result(cmd, reg_index, addr, byte_count, wdata, r);
                expected_results.push_back(r);
            end
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    // result transfer with nothing expected
                    report_mismatch("result count", 64'd1, 64'd0);
                end else begin
                    e = expected_results.pop_front();
                    if (status !== e.status)
                        report_mismatch("status", 64'(status), 64'(e.status));
                    if (rdata !== e.rdata)
                        report_mismatch("rdata", rdata, e.rdata);
                    if (pc_value !== e.pc)
                        report_mismatch("pc_value", pc_value, e.pc);
                    if (tohost_set !== e.tohost)
                        report_mismatch("tohost_set", 64'(tohost_set), 64'(e.tohost));
                    if (at_breakpoint !== e.bp_hit)
                        report_mismatch("at_breakpoint", 64'(at_breakpoint),
                                        64'(e.bp_hit));
                end
            end
        end
    end

endmodule

`default_nettype wire

/* tb/tb_rv64i_subset_exec_unit.sv */
// ---------------------------------------------------------------------------
// tb_rv64i_subset_exec_unit
// Drives debug and step items into the rv64i subset execute unit: a directed
// pass over edge cases, then small random programs loaded through the debug
// port and stepped, mixed with random noise items, under random idling.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_rv64i_subset_exec_unit
    import rvx_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 20000;
    localparam int TARGET_ITEMS  = 450;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  cmd = CMD_STEP;
    logic [5:0]  reg_index = '0;
    logic [11:0] addr = '0;
    logic [3:0]  byte_count = '0;
    logic [63:0] wdata = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [63:0] rdata;
    logic [63:0] pc_value;
    logic        tohost_set;
    logic        at_breakpoint;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          items_sent = 0;
    bit          calm = 1'b0;

    always #4 clk = ~clk;

    rv64i_subset_exec_unit dut (.*);

    rvx_exec_checker checker_i (.*);

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        int quiet;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("tb_rv64i_subset_exec_unit: errors");
            $finish;
        end
    end

    // quiet stretches with no idling on either side
    always @(posedge clk)
    begin
        int tick;
        tick++;
        if (tick % 300 == 0)
            calm <= ($urandom_range(0, 2) == 0);
    end

    // result side stall, drawn once per result
    always @(posedge clk)
    begin
        int hold;
        if (out_valid && out_stall && hold > 0)
            hold--;
        if (out_valid && !out_stall)
            hold = calm ? 0 : $urandom_range(0, 3);
        out_stall <= (hold > 0);
    end

    // instruction encoders
    function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [4:0] rs1,
                                          input logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [4:0] rs2, input logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_r(input logic [6:0] op, input logic [4:0] rd,
                                          input logic [4:0] rs1, input logic [4:0] rs2);
        return {F7_ADD, rs2, rs1, F3_ADD, rd, op};
    endfunction

    function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] off);
        return {off[20], off[10:1], off[11], off[19:12], rd, OP_JAL};
    endfunction

    // mostly small data offsets, sometimes any 12-bit value
    function automatic logic [11:0] data_imm();
        if ($urandom_range(0, 4) == 0)
            return 12'($urandom());
        return 12'($urandom_range(0, 32)) - 12'd16;
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [4:0] rd, rs1, rs2;
        rd  = 5'($urandom_range(0, 7));
        rs1 = 5'($urandom_range(0, 7));
        rs2 = 5'($urandom_range(0, 7));
        case ($urandom_range(0, 15))
            0:  return enc_i(OP_LOAD, F3_WORD, rd, rs1, data_imm());
            1:  return enc_i(OP_LOAD, F3_DBL, rd, rs1, data_imm());
            2:  return enc_i(OP_IMM, F3_ADD, rd, rs1, 12'($urandom()));
            3:  return enc_i(OP_IMM, F3_SLT, rd, rs1, 12'($urandom()));
            4:  return {20'($urandom()), rd, OP_AUIPC};
            5:  return enc_i(OP_IMMW, F3_ADD, rd, rs1, 12'($urandom()));
            6:  return enc_s(F3_BYTE, rs1, rs2, data_imm());
            7:  return enc_s(F3_WORD, rs1, rs2, data_imm());
            8:  return enc_s(F3_DBL, rs1, rs2, data_imm());
            9:  return enc_r(OP_REG, rd, rs1, rs2);
            10: return {20'($urandom()), rd, OP_LUI};
            11: return enc_r(OP_REGW, rd, rs1, rs2);
            12: return enc_i(OP_JALR, F3_ADD, rd, rs1, 12'($urandom_range(0, 24)));
            13: return enc_j(rd, 21'($signed($urandom_range(0, 6)) - 2) << 2);
            14: return {7'($urandom_range(1, 127)), 18'($urandom()), OP_REG};
            default: return $urandom();
        endcase
    endfunction

    // one item transfer, with a random gap ahead of it
    task automatic send_item(input logic [2:0] c, input logic [5:0] ri,
                             input logic [11:0] a, input logic [3:0] n,
                             input logic [63:0] wd);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        reg_index  <= ri;
        addr       <= a;
        byte_count <= n;
        wdata      <= wd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // load a short random program, point pc at it and step through it
    task automatic run_program();
        int unsigned base, len;
        logic [63:0] lim;
        base = 4 * $urandom_range(0, 1000);
        len  = $urandom_range(3, 8);
        for (int r = 1; r <= 3; r++)
            send_item(CMD_WRREG, 6'(r), '0, '0,
                      ($urandom_range(0, 3) == 0) ? 64'd4092 : 64'($urandom_range(0, 4095)));
        if ($urandom_range(0, 3) == 0)
            send_item(CMD_WRREG, 6'($urandom_range(4, 7)), '0, '0, {$urandom(), $urandom()});
        for (int unsigned i = 0; i < len; i++)
            send_item(CMD_WRMEM, '0, 12'(base + 4 * i), 4'd4, {32'($urandom()), rand_instr()});
        send_item(CMD_WRREG, REG_PC, '0, '0, 64'(base));
        wait_idle();
        case ($urandom_range(0, 5))
            0:       lim = 64'd4096;
            1:       lim = 64'h1fff;
            default: lim = 64'(base + 4 * len);
        endcase
        write_cfg(CFG_CODE_LIMIT, lim);
        if ($urandom_range(0, 3) == 0) begin
            write_cfg(CFG_BP_EN, 64'($urandom_range(0, 1)));
            write_cfg(CFG_BP_ADDR, 64'(base + 4 * $urandom_range(0, len)));
        end
        for (int unsigned i = 0; i < len + 2; i++)
            send_item(CMD_STEP, 6'($urandom()), 12'($urandom()), 4'($urandom()),
                      {$urandom(), $urandom()});
    endtask

    task automatic send_noise();
        send_item(3'($urandom()), 6'($urandom()), 12'($urandom()), 4'($urandom()),
                  {$urandom(), $urandom()});
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: register port edges, memory length faults, unknown commands
        send_item(CMD_RDREG, 6'd0, '0, '0, '0);
        send_item(CMD_WRREG, 6'd0, '0, '0, '1);
        send_item(CMD_RDREG, 6'd0, '0, '0, '0);
        send_item(CMD_RDREG, 6'd2, '0, '0, '0);
        send_item(CMD_RDREG, REG_PC, '0, '0, '0);
        send_item(CMD_RDREG, 6'd33, '0, '0, '0);
        send_item(CMD_WRREG, 6'd63, '0, '0, '1);
        send_item(CMD_RDMEM, '0, 12'd0, 4'd0, '0);
        send_item(CMD_RDMEM, '0, 12'd0, 4'd9, '0);
        send_item(CMD_WRMEM, '0, 12'd4089, 4'd8, '1);
        send_item(CMD_RDMEM, '0, 12'hfff, 4'd1, '0);
        send_item(CMD_WRMEM, '0, 12'd4088, 4'd8, '1);
        send_item(CMD_RDMEM, '0, 12'd4088, 4'd8, '0);
        send_item(3'd5, '1, '1, '1, '1);
        send_item(3'd7, '0, '0, '0, '0);
        // step with a zero code limit
        send_item(CMD_STEP, '0, '0, '0, '0);

        // lw sign extension, jalr with rd equal to rs1, illegal, fetch fault
        send_item(CMD_WRMEM, '0, 12'h100, 4'd4, 64'h8000_0000);
        send_item(CMD_WRREG, 6'd1, '0, '0, 64'h100);
        send_item(CMD_WRMEM, '0, 12'd0, 4'd8,
                  {enc_i(OP_JALR, F3_ADD, 5'd5, 5'd5, 12'd8),
                   enc_i(OP_LOAD, F3_WORD, 5'd3, 5'd1, 12'd0)});
        send_item(CMD_WRMEM, '0, 12'd8, 4'd4, 64'hffff_ffff);
        wait_idle();
        write_cfg(CFG_CODE_LIMIT, 64'd4096);
        write_cfg(CFG_BP_EN, 64'd1);
        write_cfg(CFG_BP_ADDR, 64'd8);
        repeat (3)
            send_item(CMD_STEP, '0, '0, '0, '0);
        send_item(CMD_RDREG, 6'd3, '0, '0, '0);
        send_item(CMD_WRREG, REG_PC, '0, '0, 64'd4094);
        send_item(CMD_STEP, '0, '0, '0, '0);
        wait_idle();
        write_cfg(CFG_BP_ADDR, '1);
        write_cfg(CFG_BP_EN, 64'd0);
        write_cfg(CFG_BP_ADDR, 64'd0);

        // random programs mixed with noise
        while (items_sent < TARGET_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat (5) send_noise();
                wait_idle();
                write_cfg(CFG_CODE_LIMIT, 64'($urandom()));
            end else begin
                run_program();
            end
        end

        wait_idle();
        write_cfg(CFG_CODE_LIMIT, 64'd0);
        write_cfg(CFG_BP_EN, 64'd1);
        write_cfg(CFG_BP_ADDR, 64'd0);
        send_item(CMD_WRREG, REG_PC, '0, '0, 64'd0);
        send_item(CMD_STEP, '0, '0, '0, '0);
        wait_idle();

        if (errors == 0)
            $display("tb_rv64i_subset_exec_unit: clean");
        else
            $display("tb_rv64i_subset_exec_unit: errors");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/rvx_pkg.sv
src/rvx_ctrl.sv
src/rvx_dp.sv
src/rv64i_subset_exec_unit.sv
tb/rvx_exec_checker.sv
tb/tb_rv64i_subset_exec_unit.sv
